// File: sv/swt_pkg.sv
// Shared types, constants and helper functions of the sensor window tracker.
package swt_pkg;

   // Signed working width: every sum of fields and margins fits with room to spare.
   localparam int SVAL_W = 16;
   typedef logic signed [SVAL_W-1:0] sval_type;

   // Largest window size the sensor supports; sizes saturate here.
   localparam int       MAX_DIM   = 4096;
   localparam sval_type MAX_DIM_S = sval_type'(MAX_DIM);

   // Gain pacing and the hold-off before a window and gain reset.
   localparam logic [7:0] GAIN_INTERVAL  = 8'd100;
   localparam logic [7:0] RESET_HOLDOFF  = 8'd25;
   localparam logic [7:0] FRAMES_SAT     = 8'd255;

   // Register file geometry.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_MARGIN_ROWS      = 3'd0,
      REG_MARGIN_COLS      = 3'd1,
      REG_MOVE_SLACK_ROWS  = 3'd2,
      REG_MOVE_SLACK_COLS  = 3'd3,
      REG_MIN_ROWS         = 3'd4,
      REG_MIN_COLS         = 3'd5,
      REG_HOME_OFFSET_ROWS = 3'd6,
      REG_HOME_ROWS        = 3'd7
   } cfg_index_type;

   localparam logic [9:0]  RST_MARGIN_ROWS      = 10'd20;
   localparam logic [9:0]  RST_MARGIN_COLS      = 10'd20;
   localparam logic [9:0]  RST_MOVE_SLACK_ROWS  = 10'd10;
   localparam logic [9:0]  RST_MOVE_SLACK_COLS  = 10'd10;
   localparam logic [12:0] RST_MIN_ROWS         = 13'd200;
   localparam logic [12:0] RST_MIN_COLS         = 13'd400;
   localparam logic [11:0] RST_HOME_OFFSET_ROWS = 12'd0;
   localparam logic [12:0] RST_HOME_ROWS        = 13'd4096;

   // One input word: the frame's parse outcome, feature limits and current window.
   typedef struct packed {
      logic        parse_ok;
      logic        history_present;
      logic [11:0] feature_top;
      logic [11:0] feature_bottom;
      logic [11:0] cur_row_offset;
      logic [12:0] cur_rows;
      logic [11:0] cur_col_offset;
      logic [12:0] cur_cols;
      logic [12:0] full_cols;
      logic [12:0] edge_left;
      logic [12:0] edge_right;
      logic        gain_hint;
   } req_word_type;

   // One result word: window commands, the pending crop and gain decisions.
   typedef struct packed {
      logic        set_vertical;
      logic [11:0] new_row_offset;
      logic [12:0] new_rows;
      logic        crop_pending;
      logic [11:0] crop_col_offset;
      logic [12:0] crop_cols;
      logic        apply_gain;
      logic        reset_window_gain;
   } rsp_word_type;

   function automatic sval_type abs_s(input sval_type a);
      return (a < 0) ? -a : a;
   endfunction

   function automatic sval_type min_s(input sval_type a, input sval_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic sval_type max_s(input sval_type a, input sval_type b);
      return (a > b) ? a : b;
   endfunction

   // A programmed minimum of zero acts as one; minimums saturate at the sensor size.
   function automatic sval_type eff_min(input logic [12:0] v);
      sval_type m;
      m = sval_type'(v);
      if (m < sval_type'(1)) begin
         m = sval_type'(1);
      end
      return min_s(m, MAX_DIM_S);
   endfunction

endpackage

// File: sv/swt_if.sv
// Valid/ready channel interfaces for the request and response words.
interface swt_req_if import swt_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface swt_rsp_if import swt_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: sv/sensor_window_tracker.sv
// Top level of the sensor window tracker: input stage, window logic and result stage.
//
// The tracker takes one word per camera frame and answers with exactly one result word.
// An accepted word waits in an input register until the result register can take a word;
// then the window logic evaluates it against the pending vertical and horizontal requests
// and the gain counter, updates that state and loads the result register, from which the
// result word is offered on the response channel. A new word can be taken in every cycle
// while results are taken, so the sustained rate is one word per cycle. That figure is set
// by the state update loop in the window logic stage, whose registers are updated as each
// word leaves the input register, so the next word always sees the state left by the
// previous one. While a finished result waits to be taken, the input register can still
// take one more word; after that the request channel holds ready low until the result is
// taken. The eight setup registers sit on an APB-style port at byte addresses 4*i; they
// should be written only while no word is in flight.
module sensor_window_tracker import swt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   swt_req_if.sink               req_chan,
   swt_rsp_if.source             rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // ------------------------------------------------------------------
   // Setup registers.
   // ------------------------------------------------------------------
   logic [9:0]    margin_rows_ff;
   logic [9:0]    margin_cols_ff;
   logic [9:0]    move_slack_rows_ff;
   logic [9:0]    move_slack_cols_ff;
   logic [12:0]   min_rows_ff;
   logic [12:0]   min_cols_ff;
   logic [11:0]   home_offset_rows_ff;
   logic [12:0]   home_rows_ff;
   cfg_index_type csr_index;
   logic          csr_write;

   assign pready    = 1'b1;
   assign csr_index = cfg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_rows_ff      <= RST_MARGIN_ROWS;
         margin_cols_ff      <= RST_MARGIN_COLS;
         move_slack_rows_ff  <= RST_MOVE_SLACK_ROWS;
         move_slack_cols_ff  <= RST_MOVE_SLACK_COLS;
         min_rows_ff         <= RST_MIN_ROWS;
         min_cols_ff         <= RST_MIN_COLS;
         home_offset_rows_ff <= RST_HOME_OFFSET_ROWS;
         home_rows_ff        <= RST_HOME_ROWS;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_MARGIN_ROWS:      margin_rows_ff      <= pwdata[9:0];
            REG_MARGIN_COLS:      margin_cols_ff      <= pwdata[9:0];
            REG_MOVE_SLACK_ROWS:  move_slack_rows_ff  <= pwdata[9:0];
            REG_MOVE_SLACK_COLS:  move_slack_cols_ff  <= pwdata[9:0];
            REG_MIN_ROWS:         min_rows_ff         <= pwdata[12:0];
            REG_MIN_COLS:         min_cols_ff         <= pwdata[12:0];
            REG_HOME_OFFSET_ROWS: home_offset_rows_ff <= pwdata[11:0];
            REG_HOME_ROWS:        home_rows_ff        <= pwdata[12:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_MARGIN_ROWS:      prdata = CSR_DATA_W'(margin_rows_ff);
         REG_MARGIN_COLS:      prdata = CSR_DATA_W'(margin_cols_ff);
         REG_MOVE_SLACK_ROWS:  prdata = CSR_DATA_W'(move_slack_rows_ff);
         REG_MOVE_SLACK_COLS:  prdata = CSR_DATA_W'(move_slack_cols_ff);
         REG_MIN_ROWS:         prdata = CSR_DATA_W'(min_rows_ff);
         REG_MIN_COLS:         prdata = CSR_DATA_W'(min_cols_ff);
         REG_HOME_OFFSET_ROWS: prdata = CSR_DATA_W'(home_offset_rows_ff);
         REG_HOME_ROWS:        prdata = CSR_DATA_W'(home_rows_ff);
      endcase
   end

   // ------------------------------------------------------------------
   // Handshake. The input register drains whenever the result register
   // can take a word, so a word may enter on every cycle.
   // ------------------------------------------------------------------
   logic         s1_valid_ff, s1_valid_in;
   req_word_type s1_word_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff, out_word_in;
   logic         advance;
   logic         fire;
   logic         accept;

   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign fire           = s1_valid_ff && advance;
   assign req_chan.ready = !s1_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_word_ff;

   assign s1_valid_in  = accept ? 1'b1 : (fire ? 1'b0 : s1_valid_ff);
   assign out_valid_in = fire ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);

   // ------------------------------------------------------------------
   // Tracker state.
   // ------------------------------------------------------------------
   logic        vpend_valid_ff, vpend_valid_in;
   logic [11:0] vpend_offset_ff, vpend_offset_in;
   logic [12:0] vpend_rows_ff, vpend_rows_in;
   logic        hpend_valid_ff, hpend_valid_in;
   logic [11:0] hpend_offset_ff, hpend_offset_in;
   logic [12:0] hpend_cols_ff, hpend_cols_in;
   logic [7:0]  frames_since_gain_ff, frames_since_gain_in;

   // ------------------------------------------------------------------
   // Operands, widened to the signed working width.
   // ------------------------------------------------------------------
   sval_type top_s, bot_s, roff_s, rows_s, coff_s, cols_s, fullc_s;
   sval_type el_raw, er_raw, el_s, er_s;
   sval_type mr_s, mc_s, sr_s, sc_s, minr_s, minc_s;

   assign top_s   = sval_type'(s1_word_ff.feature_top);
   assign bot_s   = sval_type'(s1_word_ff.feature_bottom);
   assign roff_s  = sval_type'(s1_word_ff.cur_row_offset);
   assign rows_s  = sval_type'(s1_word_ff.cur_rows);
   assign coff_s  = sval_type'(s1_word_ff.cur_col_offset);
   assign cols_s  = sval_type'(s1_word_ff.cur_cols);
   assign fullc_s = sval_type'(s1_word_ff.full_cols);
   assign el_raw  = sval_type'(s1_word_ff.edge_left);
   assign er_raw  = sval_type'(s1_word_ff.edge_right);
   assign mr_s    = sval_type'(margin_rows_ff);
   assign mc_s    = sval_type'(margin_cols_ff);
   assign sr_s    = sval_type'(move_slack_rows_ff);
   assign sc_s    = sval_type'(move_slack_cols_ff);
   assign minr_s  = eff_min(min_rows_ff);
   assign minc_s  = eff_min(min_cols_ff);

   // Edges given in the wrong order are swapped.
   assign el_s = (el_raw > er_raw) ? er_raw : el_raw;
   assign er_s = (el_raw > er_raw) ? el_raw : er_raw;

   // ------------------------------------------------------------------
   // Vertical window. A pending request counts as applied only when both
   // offset and height show up in the frame. A short window grows about
   // its centre, half the shortfall going above the feature.
   // ------------------------------------------------------------------
   logic     v_match, v_covers, v_dev, v_short, v_changed;
   sval_type v_o0, v_h0, v_adj, v_o, v_h;

   assign v_match  = !vpend_valid_ff ||
                     ((vpend_offset_ff == s1_word_ff.cur_row_offset) &&
                      (vpend_rows_ff == s1_word_ff.cur_rows));
   assign v_covers = (rows_s == minr_s) &&
                     ((bot_s - top_s + (mr_s <<< 1)) <= minr_s) &&
                     ((roff_s + mr_s) <= top_s) &&
                     ((bot_s + mr_s) <= (roff_s + rows_s));
   assign v_dev    = (abs_s(top_s - mr_s - roff_s) > sr_s) ||
                     (abs_s(bot_s + mr_s - roff_s - rows_s) > sr_s);
   assign v_o0     = (top_s > mr_s) ? (top_s - mr_s) : '0;
   assign v_h0     = bot_s - v_o0 + mr_s;
   assign v_short  = v_h0 < minr_s;
   assign v_adj    = (minr_s - v_h0) >>> 1;
   assign v_o      = v_short ? ((v_o0 > v_adj) ? (v_o0 - v_adj) : '0) : v_o0;
   assign v_h      = min_s(v_short ? minr_s : v_h0, MAX_DIM_S);
   assign v_changed = (v_o != roff_s) || (v_h != rows_s);

   // ------------------------------------------------------------------
   // Horizontal crop. A pending request counts as applied when the width
   // alone matches. A crop narrower than the minimum is recentred on the
   // feature and clamped inside the frame.
   // ------------------------------------------------------------------
   logic     h_match, h_covers, h_dev, h_short, h_changed;
   sval_type h_nl0, h_nr, h_ext, h_w0, h_cw, h_ctr, h_ml, h_cl, h_nl, h_w;

   assign h_match  = !hpend_valid_ff || (hpend_cols_ff == s1_word_ff.cur_cols);
   assign h_covers = (cols_s == minc_s) &&
                     ((er_s - el_s + (mc_s <<< 1)) <= minc_s) &&
                     ((coff_s + mc_s) <= el_s) &&
                     ((er_s + mc_s) <= (coff_s + cols_s));
   assign h_dev    = (abs_s(el_s - mc_s - coff_s) > sc_s) ||
                     (abs_s(er_s + mc_s - coff_s - cols_s) > sc_s);
   assign h_nl0    = max_s('0, el_s - mc_s);
   assign h_nr     = min_s(fullc_s, er_s + mc_s);
   assign h_ext    = max_s('0, h_nr - h_nl0);
   assign h_w0     = min_s(max_s(minc_s, h_ext), max_s('0, fullc_s - h_nl0));
   assign h_short  = h_w0 < minc_s;
   assign h_cw     = min_s(minc_s, fullc_s);
   assign h_ctr    = (el_s + er_s) >>> 1;
   assign h_ml     = max_s('0, fullc_s - h_cw);
   assign h_cl     = min_s(max_s('0, h_ctr - (h_cw >>> 1)), h_ml);
   assign h_nl     = h_short ? h_cl : h_nl0;
   assign h_w      = min_s(h_short ? h_cw : h_w0, MAX_DIM_S);
   assign h_changed = (h_nl != coff_s) || (h_w != cols_s);

   // ------------------------------------------------------------------
   // Gain pacing: successful frames are counted, saturating.
   // ------------------------------------------------------------------
   logic [7:0] frames_inc;
   logic       set_v, gain, rst_home;

   assign frames_inc = (frames_since_gain_ff == FRAMES_SAT) ? frames_since_gain_ff
                                                            : frames_since_gain_ff + 8'd1;

   always_comb begin
      set_v                = 1'b0;
      gain                 = 1'b0;
      rst_home             = 1'b0;
      vpend_valid_in       = vpend_valid_ff;
      vpend_offset_in      = vpend_offset_ff;
      vpend_rows_in        = vpend_rows_ff;
      hpend_valid_in       = hpend_valid_ff;
      hpend_offset_in      = hpend_offset_ff;
      hpend_cols_in        = hpend_cols_ff;
      frames_since_gain_in = frames_since_gain_ff;
      if (fire) begin
         if (s1_word_ff.parse_ok) begin
            if (v_match) begin
               if (!v_covers && v_dev) begin
                  // A window equal to the current one leaves the request alone.
                  if (v_changed) begin
                     vpend_valid_in  = 1'b1;
                     vpend_offset_in = v_o[11:0];
                     vpend_rows_in   = v_h[12:0];
                     set_v           = 1'b1;
                  end
               end else begin
                  vpend_valid_in = 1'b0;
               end
            end
            if (h_match) begin
               hpend_valid_in = 1'b0;
               if (!h_covers && h_dev && h_changed) begin
                  hpend_valid_in  = 1'b1;
                  hpend_offset_in = h_nl[11:0];
                  hpend_cols_in   = h_w[12:0];
               end
            end
            if ((frames_inc > GAIN_INTERVAL) && s1_word_ff.gain_hint) begin
               gain                 = 1'b1;
               frames_since_gain_in = '0;
            end else begin
               frames_since_gain_in = frames_inc;
            end
         end else if (!s1_word_ff.history_present) begin
            // Lost track with no history: send the window and gain home.
            if (!vpend_valid_ff && (s1_word_ff.cur_row_offset != '0) &&
                (frames_since_gain_ff > RESET_HOLDOFF)) begin
               rst_home        = 1'b1;
               vpend_valid_in  = 1'b1;
               vpend_offset_in = home_offset_rows_ff;
               vpend_rows_in   = home_rows_ff;
            end
         end
      end
   end

   always_comb begin
      out_word_in.set_vertical      = set_v;
      out_word_in.new_row_offset    = set_v ? v_o[11:0] : '0;
      out_word_in.new_rows          = set_v ? v_h[12:0] : '0;
      out_word_in.crop_pending      = hpend_valid_in;
      out_word_in.crop_col_offset   = hpend_valid_in ? hpend_offset_in : '0;
      out_word_in.crop_cols         = hpend_valid_in ? hpend_cols_in : '0;
      out_word_in.apply_gain        = gain;
      out_word_in.reset_window_gain = rst_home;
   end

   // ------------------------------------------------------------------
   // Registers.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff          <= 1'b0;
         out_valid_ff         <= 1'b0;
         vpend_valid_ff       <= 1'b0;
         vpend_offset_ff      <= '0;
         vpend_rows_ff        <= '0;
         hpend_valid_ff       <= 1'b0;
         hpend_offset_ff      <= '0;
         hpend_cols_ff        <= '0;
         frames_since_gain_ff <= '0;
      end else begin
         s1_valid_ff          <= s1_valid_in;
         out_valid_ff         <= out_valid_in;
         vpend_valid_ff       <= vpend_valid_in;
         vpend_offset_ff      <= vpend_offset_in;
         vpend_rows_ff        <= vpend_rows_in;
         hpend_valid_ff       <= hpend_valid_in;
         hpend_offset_ff      <= hpend_offset_in;
         hpend_cols_ff        <= hpend_cols_in;
         frames_since_gain_ff <= frames_since_gain_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_word_ff <= req_chan.data;
      end
      if (fire) begin
         out_word_ff <= out_word_in;
      end
   end

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   // Window commands and gain changes come from successful frames, a home reset only
   // from a failed one.
   a_setv_vs_home: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !(rsp_chan.data.set_vertical && rsp_chan.data.reset_window_gain))
      else $error("vertical command and home reset in the same word");

   a_gain_vs_home: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !(rsp_chan.data.apply_gain && rsp_chan.data.reset_window_gain))
      else $error("gain change and home reset in the same word");

   // Without a pending crop the crop fields read as zero.
   a_crop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.data.crop_pending) |->
      ((rsp_chan.data.crop_col_offset == '0) && (rsp_chan.data.crop_cols == '0)))
      else $error("crop fields set without a pending crop");

   // A commanded vertical window is remembered as pending.
   a_setv_pends: assert property (@(posedge clock) disable iff (reset)
      (fire && set_v) |=> (vpend_valid_ff && (vpend_rows_ff == $past(v_h[12:0]))))
      else $error("vertical command not recorded as pending");

   // Applying gain restarts the pacing count.
   a_gain_clears: assert property (@(posedge clock) disable iff (reset)
      (fire && gain) |=> (frames_since_gain_ff == '0))
      else $error("gain pacing counter not cleared");

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the sensor window tracker: predictor, scoreboard and drivers.
`timescale 1ns / 1ps

module tb_top import swt_pkg::*;;

   // Cycles without any accepted word before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 2000;
   // Two register stages between the request and response channels.
   localparam int DRAIN_CYCLES   = 4;
   localparam int REQ_W          = $bits(req_word_type);
   localparam int PHASE_ITEMS    = 80;
   localparam int PHASE_COUNT    = 8;

   typedef enum {
      PH_ZERO,
      PH_ONES,
      PH_WILD,
      PH_TYPICAL
   } phase_kind_type;

   // Tracks the window and gain state of the block and queues the command word that
   // each accepted frame should produce.
   class window_tracker_model;
      int unsigned  regs [8];
      bit           vpend_valid;
      int           vpend_offset;
      int           vpend_rows;
      bit           hpend_valid;
      int           hpend_offset;
      int           hpend_cols;
      int           frames_since_gain;
      rsp_word_type pending_commands [$];
      int           errors;

      function new();
         regs[REG_MARGIN_ROWS]      = RST_MARGIN_ROWS;
         regs[REG_MARGIN_COLS]      = RST_MARGIN_COLS;
         regs[REG_MOVE_SLACK_ROWS]  = RST_MOVE_SLACK_ROWS;
         regs[REG_MOVE_SLACK_COLS]  = RST_MOVE_SLACK_COLS;
         regs[REG_MIN_ROWS]         = RST_MIN_ROWS;
         regs[REG_MIN_COLS]         = RST_MIN_COLS;
         regs[REG_HOME_OFFSET_ROWS] = RST_HOME_OFFSET_ROWS;
         regs[REG_HOME_ROWS]        = RST_HOME_ROWS;
         vpend_valid       = 1'b0;
         vpend_offset      = 0;
         vpend_rows        = 0;
         hpend_valid       = 1'b0;
         hpend_offset      = 0;
         hpend_cols        = 0;
         frames_since_gain = 0;
         errors            = 0;
      endfunction

      function void write_reg(cfg_index_type idx, logic [31:0] value);
         case (idx)
            REG_MARGIN_ROWS, REG_MARGIN_COLS, REG_MOVE_SLACK_ROWS, REG_MOVE_SLACK_COLS: begin
               regs[int'(idx)] = int'(value[9:0]);
            end
            REG_HOME_OFFSET_ROWS: begin
               regs[int'(idx)] = int'(value[11:0]);
            end
            default: begin
               regs[int'(idx)] = int'(value[12:0]);
            end
         endcase
      endfunction

      function int magnitude(int a);
         return (a < 0) ? -a : a;
      endfunction

      // A programmed minimum of zero means one; minimums never exceed the sensor.
      function int effective_floor(int unsigned v);
         if (v < 1) begin
            return 1;
         end
         return (v > MAX_DIM) ? MAX_DIM : int'(v);
      endfunction

      function int outstanding();
         return pending_commands.size();
      endfunction

      function void note_frame(req_word_type w);
         int top, bot, roff, rows, coff, cols, fullc, el, er;
         int mr, mc, sr, sc, minr, minc;
         int o, h, adj, nl, nr, ext, wid, lim, cw, ctr, ml, t;
         bit fits;
         rsp_word_type r;
         top   = w.feature_top;
         bot   = w.feature_bottom;
         roff  = w.cur_row_offset;
         rows  = w.cur_rows;
         coff  = w.cur_col_offset;
         cols  = w.cur_cols;
         fullc = w.full_cols;
         el    = w.edge_left;
         er    = w.edge_right;
         mr    = regs[REG_MARGIN_ROWS];
         mc    = regs[REG_MARGIN_COLS];
         sr    = regs[REG_MOVE_SLACK_ROWS];
         sc    = regs[REG_MOVE_SLACK_COLS];
         minr  = effective_floor(regs[REG_MIN_ROWS]);
         minc  = effective_floor(regs[REG_MIN_COLS]);
         r     = '0;

         if (w.parse_ok) begin
            // Vertical axis: only act once the earlier request shows up in the frame.
            if (!vpend_valid || (vpend_offset == roff && vpend_rows == rows)) begin
               fits = (rows == minr) && (bot - top + 2 * mr <= minr) &&
                      (roff + mr <= top) && (bot + mr <= roff + rows);
               if (!fits && (magnitude(top - mr - roff) > sr ||
                             magnitude(bot + mr - (roff + rows)) > sr)) begin
                  o = (top > mr) ? top - mr : 0;
                  h = bot - o + mr;
                  if (h < minr) begin
                     adj = (minr - h) / 2;
                     o   = (o > adj) ? o - adj : 0;
                     h   = minr;
                  end
                  if (h > MAX_DIM) begin
                     h = MAX_DIM;
                  end
                  if (o != roff || h != rows) begin
                     vpend_valid      = 1'b1;
                     vpend_offset     = o;
                     vpend_rows       = h;
                     r.set_vertical   = 1'b1;
                     r.new_row_offset = 12'(o);
                     r.new_rows       = 13'(h);
                  end
               end else begin
                  vpend_valid = 1'b0;
               end
            end

            // Horizontal axis: the width alone tells whether the crop was applied.
            if (el > er) begin
               t  = el;
               el = er;
               er = t;
            end
            if (!hpend_valid || hpend_cols == cols) begin
               fits = (cols == minc) && (er - el + 2 * mc <= minc) &&
                      (coff + mc <= el) && (er + mc <= coff + cols);
               hpend_valid = 1'b0;
               if (!fits && (magnitude(el - mc - coff) > sc ||
                             magnitude(er + mc - (coff + cols)) > sc)) begin
                  nl  = (el > mc) ? el - mc : 0;
                  nr  = (er + mc < fullc) ? er + mc : fullc;
                  ext = (nr > nl) ? nr - nl : 0;
                  wid = (minc > ext) ? minc : ext;
                  lim = (fullc > nl) ? fullc - nl : 0;
                  if (wid > lim) begin
                     wid = lim;
                  end
                  if (wid < minc) begin
                     // Too close to the right edge: center a minimum window instead.
                     cw  = (minc < fullc) ? minc : fullc;
                     ctr = (el + er) / 2;
                     ml  = (fullc > cw) ? fullc - cw : 0;
                     nl  = ctr - cw / 2;
                     if (nl < 0) begin
                        nl = 0;
                     end
                     if (nl > ml) begin
                        nl = ml;
                     end
                     wid = cw;
                  end
                  if (wid > MAX_DIM) begin
                     wid = MAX_DIM;
                  end
                  if (nl != coff || wid != cols) begin
                     hpend_valid  = 1'b1;
                     hpend_offset = nl;
                     hpend_cols   = wid;
                  end
               end
            end

            if (frames_since_gain < int'(FRAMES_SAT)) begin
               frames_since_gain++;
            end
            if (frames_since_gain > int'(GAIN_INTERVAL) && w.gain_hint) begin
               r.apply_gain      = 1'b1;
               frames_since_gain = 0;
            end
         end else if (!w.history_present) begin
            if (!vpend_valid && roff != 0 && frames_since_gain > int'(RESET_HOLDOFF)) begin
               r.reset_window_gain = 1'b1;
               vpend_valid         = 1'b1;
               vpend_offset        = int'(regs[REG_HOME_OFFSET_ROWS]);
               vpend_rows          = int'(regs[REG_HOME_ROWS]);
            end
         end

         r.crop_pending = hpend_valid;
         if (hpend_valid) begin
            r.crop_col_offset = 12'(hpend_offset);
            r.crop_cols       = 13'(hpend_cols);
         end
         pending_commands.push_back(r);
      endfunction

      function void compare_field(string name, int unsigned exp, int unsigned act);
         if (exp != act) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, exp, act);
         end
      endfunction

      function void check_command(rsp_word_type got);
         rsp_word_type exp;
         if (pending_commands.size() == 0) begin
            errors++;
            $display("%0t: result word %h arrived with nothing expected", $time, got);
            return;
         end
         exp = pending_commands.pop_front();
         compare_field("set_vertical", exp.set_vertical, got.set_vertical);
         compare_field("new_row_offset", exp.new_row_offset, got.new_row_offset);
         compare_field("new_rows", exp.new_rows, got.new_rows);
         compare_field("crop_pending", exp.crop_pending, got.crop_pending);
         compare_field("crop_col_offset", exp.crop_col_offset, got.crop_col_offset);
         compare_field("crop_cols", exp.crop_cols, got.crop_cols);
         compare_field("apply_gain", exp.apply_gain, got.apply_gain);
         compare_field("reset_window_gain", exp.reset_window_gain, got.reset_window_gain);
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   swt_req_if req_if ();
   swt_rsp_if rsp_if ();

   window_tracker_model sb = new();

   // Percent of cycles in which the sender holds back a word and the receiver stalls.
   int send_idle_pct;
   int take_idle_pct;

   // What the imaginary sensor is currently doing: its window and the tracked feature.
   int s_roff, s_rows, s_coff, s_cols, s_full;
   int f_top, f_height, f_left, f_width;

   sensor_window_tracker i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side: check every accepted word, then decide whether to stall next cycle.
   // Signals are read right after the edge, so they show the values the edge sampled.
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            sb.check_command(rsp_if.data);
         end
         rsp_if.ready <= ($urandom_range(0, 99) >= take_idle_pct);
      end
   end

   // Watchdog: any handshake on either channel restarts the count.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("%0t: no word accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb_top NOT OK");
      $finish;
   end

   // Offer one frame word, with random idle cycles ahead of it, and hand it to the
   // model at the edge that accepts it. Valid stays high so the next word can follow
   // back to back.
   task automatic send_word(input req_word_type w);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= w;
      do @(posedge clock); while (!req_if.ready);
      sb.note_frame(w);
   endtask

   // Stop sending and wait until every expected result word has been taken.
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (sb.outstanding() != 0) begin
         @(posedge clock);
      end
   endtask

   // One register write: setup cycle, then the access cycle until pready. Select is left
   // high so a following write can start its setup cycle straight away.
   task automatic csr_write(input cfg_index_type idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(4 * int'(idx));
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.write_reg(idx, value);
   endtask

   // Rewrite all eight registers for the next phase of the run.
   task automatic program_phase(input phase_kind_type kind);
      logic [31:0] v;
      for (int i = 0; i < 8; i++) begin
         case (kind)
            PH_ZERO: begin
               v = '0;
            end
            PH_ONES: begin
               v = '1;
            end
            PH_WILD: begin
               v = $urandom;
            end
            default: begin
               case (cfg_index_type'(i))
                  REG_MARGIN_ROWS, REG_MARGIN_COLS: begin
                     v = $urandom_range(0, 60);
                  end
                  REG_MOVE_SLACK_ROWS, REG_MOVE_SLACK_COLS: begin
                     v = $urandom_range(0, 30);
                  end
                  REG_MIN_ROWS: begin
                     v = $urandom_range(1, 600);
                  end
                  REG_MIN_COLS: begin
                     v = $urandom_range(1, 900);
                  end
                  REG_HOME_OFFSET_ROWS: begin
                     v = $urandom_range(0, 2000);
                  end
                  default: begin
                     v = $urandom_range(1, 4096);
                  end
               endcase
            end
         endcase
         csr_write(cfg_index_type'(i), v);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   function automatic req_word_type make_frame(input int ok, hist, top, bot, roff, rows,
                                               coff, cols, full, el, er, hint);
      req_word_type f;
      f.parse_ok        = 1'(ok);
      f.history_present = 1'(hist);
      f.feature_top     = 12'(top);
      f.feature_bottom  = 12'(bot);
      f.cur_row_offset  = 12'(roff);
      f.cur_rows        = 13'(rows);
      f.cur_col_offset  = 12'(coff);
      f.cur_cols        = 13'(cols);
      f.full_cols       = 13'(full);
      f.edge_left       = 13'(el);
      f.edge_right      = 13'(er);
      f.gain_hint       = 1'(hint);
      return f;
   endfunction

   function automatic int step_walk(input int v, input int span, input int lo, input int hi);
      int n;
      n = v + int'($urandom_range(0, 2 * span)) - span;
      if (n < lo) begin
         n = lo;
      end
      if (n > hi) begin
         n = hi;
      end
      return n;
   endfunction

   // One random frame. Most frames come from a sensor that follows the pending requests,
   // usually at once and sometimes a few frames late, while the feature drifts and now
   // and then jumps. The rest are frames from a misbehaving sensor and raw noise.
   task automatic random_frame();
      req_word_type w;
      int pick, top, bot, el, er, t;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         w = req_word_type'(REQ_W'({$urandom, $urandom, $urandom, $urandom}));
      end else begin
         if (sb.vpend_valid && $urandom_range(0, 99) < 75) begin
            s_roff = sb.vpend_offset;
            s_rows = sb.vpend_rows;
         end
         if (sb.hpend_valid && $urandom_range(0, 99) < 75) begin
            s_coff = sb.hpend_offset;
            s_cols = sb.hpend_cols;
         end
         if (pick < 18) begin
            // The sensor took some other window than the one requested.
            if ($urandom_range(0, 1)) begin
               s_roff = $urandom_range(0, 4095);
               s_rows = $urandom_range(1, 4096);
            end else begin
               s_coff = $urandom_range(0, 4095);
               s_cols = $urandom_range(1, 4096);
            end
         end
         if ($urandom_range(0, 99) < 4) begin
            f_top  = $urandom_range(0, 4095);
            f_left = $urandom_range(0, 4096);
         end
         f_top    = step_walk(f_top, 12, 0, 4095);
         f_height = step_walk(f_height, 10, 0, 700);
         f_left   = step_walk(f_left, 12, 0, 4096);
         f_width  = step_walk(f_width, 10, 0, 1500);
         top = f_top;
         bot = (f_top + f_height > 4095) ? 4095 : f_top + f_height;
         if ($urandom_range(0, 99) < 3) begin
            t   = top;
            top = bot;
            bot = t;
         end
         el = f_left;
         er = (f_left + f_width > 4096) ? 4096 : f_left + f_width;
         if ($urandom_range(0, 99) < 10) begin
            t  = el;
            el = er;
            er = t;
         end
         if ($urandom_range(0, 99) < 3) begin
            // Column projection failed upstream.
            el = 0;
            er = s_full;
         end
         w = make_frame(($urandom_range(0, 99) < 88), $urandom_range(0, 1), top, bot,
                        s_roff, s_rows, s_coff, s_cols, s_full, el, er, $urandom_range(0, 1));
      end
      send_word(w);
   endtask

   initial begin : main_seq
      reset        <= 1'b1;
      psel         <= 1'b0;
      penable      <= 1'b0;
      pwrite       <= 1'b0;
      paddr        <= '0;
      pwdata       <= '0;
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      send_idle_pct = 33;
      take_idle_pct = 33;
      s_roff   = 0;
      s_rows   = 4096;
      s_coff   = 0;
      s_cols   = 4096;
      s_full   = 4096;
      f_top    = 1500;
      f_height = 200;
      f_left   = 1500;
      f_width  = 300;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed frames with the reset register values.
      // Small window already covering the feature on both axes.
      send_word(make_frame(1, 0, 1030, 1100, 1000, 200, 500, 400, 4096, 530, 700, 0));
      // Computed windows equal to the current ones.
      send_word(make_frame(1, 0, 5, 1000, 0, 1020, 0, 1020, 4096, 5, 1000, 0));
      // Bottom above top and swapped column edges.
      send_word(make_frame(1, 0, 3000, 100, 500, 1000, 100, 2000, 4096, 3000, 100, 1));
      // Both requests applied; a minimum-height window covers the feature and the crop fits.
      send_word(make_frame(1, 1, 1480, 1600, 1450, 200, 80, 2940, 4096, 100, 3000, 0));
      // Zero full column count.
      send_word(make_frame(1, 0, 100, 200, 0, 4096, 0, 4096, 0, 100, 200, 0));
      send_word(req_word_type'('1));
      send_word(req_word_type'('0));
      send_word(make_frame(0, 1, 10, 20, 300, 400, 10, 500, 4096, 10, 20, 1));
      send_word(make_frame(1, 0, 4095, 4095, 4095, 4096, 4095, 4096, 4096, 4096, 4096, 1));
      send_word(make_frame(1, 1, 0, 0, 0, 1, 0, 1, 1, 0, 0, 1));
      // Failed column projection as the feeder reports it.
      send_word(make_frame(1, 0, 500, 900, 400, 600, 0, 4096, 4096, 0, 4096, 0));
      // Values beyond the sensor size in every 13-bit field.
      send_word(make_frame(1, 0, 200, 300, 100, 8191, 100, 8191, 8191, 8191, 5000, 1));
      // A failed parse with no history and a nonzero offset, still inside the hold-off.
      send_word(make_frame(0, 0, 0, 0, 700, 300, 0, 4096, 4096, 0, 0, 0));
      wait_drained();

      // Random phases, each under its own register setting. Zeros and all ones are the
      // extremes; the wild phase writes random 32-bit data to exercise field masking.
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         case (ph)
            0: program_phase(PH_ZERO);
            1: program_phase(PH_ONES);
            2: program_phase(PH_WILD);
            default: program_phase(PH_TYPICAL);
         endcase
         s_full = ($urandom_range(0, 1) != 0) ? 4096 : int'($urandom_range(1, 4096));
         // One whole phase runs with neither side idling.
         send_idle_pct = (ph == 4) ? 0 : 33;
         take_idle_pct = (ph == 4) ? 0 : 33;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (ph == 5 && k == PHASE_ITEMS / 2) begin
               wait_drained();
            end
            random_frame();
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.outstanding() != 0) begin
         $display("%0t: %0d result words never arrived", $time, sb.outstanding());
      end
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

// File: sensor_window_tracker.f
sv/swt_pkg.sv
sv/swt_if.sv
sv/sensor_window_tracker.sv
test/tb_top.sv
